// File: rtl/fhbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhbc_pkg
// Shared types and constants for the float / half / bfloat16 converter.
// ----------------------------------------------------------------------------
package fhbc_pkg;

    typedef enum logic [1:0] {
        MODE_HALF_TO_SINGLE  = 2'd0,
        MODE_SINGLE_TO_HALF  = 2'd1,
        MODE_BF16_TO_SINGLE  = 2'd2,
        MODE_SINGLE_TO_BF16  = 2'd3
    } mode_t;

    // single-to-half range class
    typedef enum logic [1:0] {
        CAT_ZERO   = 2'd0,
        CAT_SUB    = 2'd1,
        CAT_NORM   = 2'd2,
        CAT_NAN    = 2'd3
    } s2h_cat_t;

    localparam logic [30:0] S2H_TINY_LIMIT  = 31'h3300_0001;
    localparam logic [30:0] S2H_SUB_LIMIT   = 31'h3880_0000;
    localparam logic [30:0] S2H_CLAMP_LIMIT = 31'h4780_0001;
    localparam logic [30:0] S2H_CLAMP_VALUE = 31'h4780_0000;
    localparam logic [30:0] SINGLE_INF_MAG  = 31'h7f80_0000;
    localparam logic [31:0] H2S_REBIAS      = 32'h3800_0000;
    localparam logic [31:0] SINGLE_EXP_ONES = 32'h7f80_0000;
    localparam logic [14:0] S2H_REBIAS      = 15'h4000;
    localparam logic [7:0]  H2S_SUB_BIAS    = 8'd103;
    localparam logic [7:0]  S2H_SUB_BASE    = 8'd126;
    localparam logic [31:0] BF16_NAN        = 32'h0000_7fa0;

endpackage
`default_nettype wire

// File: rtl/float_half_bfloat_convert_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_half_bfloat_convert_unit
// Single <-> half and single <-> bfloat16 conversion, round to nearest even.
// ----------------------------------------------------------------------------
// Takes one request per cycle while m_tready allows. A request passes the
// input register (classify), two pipeline stages (shift/add, round/select)
// and the output register before it shows up on m_tvalid. The pipeline holds
// on back-pressure; the output skid entry keeps s_tready registered, so one
// request per cycle is sustained whenever m_tready stays high.
module float_half_bfloat_convert_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] result
);

    logic en;

    // stage 1: input register
    logic                v1_reg;
    fhbc_pkg::mode_t     mode1_reg;
    logic [31:0]         value1_reg;

    // stage 1 classification
    logic [14:0]         c1_hmag;
    logic                c1_hzero;
    logic                c1_hsub;
    logic                c1_hinf;
    logic [3:0]          c1_lead;
    logic [30:0]         c1_smag;
    fhbc_pkg::s2h_cat_t  c1_cat;
    logic                c1_clamp;
    logic [7:0]          c1_sh8;
    logic                c1_bnan;

    // stage 2
    logic                v2_reg;
    fhbc_pkg::mode_t     mode2_reg;
    logic [31:0]         value2_reg;
    logic                hzero2_reg;
    logic                hsub2_reg;
    logic                hinf2_reg;
    logic [3:0]          lead2_reg;
    fhbc_pkg::s2h_cat_t  cat2_reg;
    logic                clamp2_reg;
    logic [4:0]          sh2_reg;
    logic                bnan2_reg;

    logic [31:0]         c2_sign;
    logic [7:0]          c2_hexp;
    logic [4:0]          c2_hshamt;
    logic [22:0]         c2_hbase;
    logic [22:0]         c2_hfrac;
    logic [31:0]         c2_hnorm;
    logic [31:0]         c2_wide;
    logic [47:0]         c2_subshift;
    logic [30:0]         c2_magc;
    logic [30:0]         c2_nsum;
    logic [14:0]         c2_n15;
    logic [32:0]         c2_bsum;

    // stage 3
    logic                v3_reg;
    fhbc_pkg::mode_t     mode3_reg;
    logic                sign3_reg;
    fhbc_pkg::s2h_cat_t  cat3_reg;
    logic [31:0]         wide3_reg;
    logic [10:0]         q3_reg;
    logic                guard3_reg;
    logic                sticky3_reg;
    logic [14:0]         n15_3_reg;
    logic [8:0]          pay3_reg;
    logic                bnan3_reg;
    logic [15:0]         bf3_reg;

    logic [10:0]         c3_qr;
    logic [31:0]         c3_result;

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg  <= fhbc_pkg::mode_t'(s_tuser);
            value1_reg <= s_tdata;
        end
    end

    assign c1_hmag  = value1_reg[14:0];
    assign c1_hzero = (c1_hmag == 15'd0);
    assign c1_hsub  = (c1_hmag[14:10] == 5'd0);
    assign c1_hinf  = (c1_hmag[14:10] == 5'h1f);

    always_comb
    begin
        c1_lead = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (value1_reg[i])
            begin
                c1_lead = 4'(i);
            end
        end
    end

    assign c1_smag  = value1_reg[30:0];
    assign c1_clamp = (c1_smag >= fhbc_pkg::S2H_CLAMP_LIMIT);
    assign c1_sh8   = fhbc_pkg::S2H_SUB_BASE - c1_smag[30:23];
    assign c1_bnan  = (value1_reg[30:23] == 8'hff) && (value1_reg[15:0] != 16'd0);

    always_comb
    begin
        if (c1_smag < fhbc_pkg::S2H_TINY_LIMIT)
        begin
            c1_cat = fhbc_pkg::CAT_ZERO;
        end
        else if (c1_smag < fhbc_pkg::S2H_SUB_LIMIT)
        begin
            c1_cat = fhbc_pkg::CAT_SUB;
        end
        else if (c1_smag > fhbc_pkg::SINGLE_INF_MAG)
        begin
            c1_cat = fhbc_pkg::CAT_NAN;
        end
        else
        begin
            c1_cat = fhbc_pkg::CAT_NORM;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode2_reg  <= mode1_reg;
            value2_reg <= value1_reg;
            hzero2_reg <= c1_hzero;
            hsub2_reg  <= c1_hsub;
            hinf2_reg  <= c1_hinf;
            lead2_reg  <= c1_lead;
            cat2_reg   <= c1_cat;
            clamp2_reg <= c1_clamp;
            sh2_reg    <= c1_sh8[4:0];
            bnan2_reg  <= c1_bnan;
        end
    end

    // half to single
    assign c2_sign   = {value2_reg[15], 31'd0};
    assign c2_hexp   = {4'd0, lead2_reg} + fhbc_pkg::H2S_SUB_BIAS;
    assign c2_hshamt = 5'd23 - {1'b0, lead2_reg};
    assign c2_hbase  = {13'd0, value2_reg[9:0]};
    assign c2_hfrac  = c2_hbase << c2_hshamt;

    always_comb
    begin
        c2_hnorm = {4'd0, value2_reg[14:0], 13'd0} + fhbc_pkg::H2S_REBIAS;
        if (hinf2_reg)
        begin
            c2_hnorm = c2_hnorm | fhbc_pkg::SINGLE_EXP_ONES;
        end
    end

    always_comb
    begin
        if (mode2_reg == fhbc_pkg::MODE_BF16_TO_SINGLE)
        begin
            c2_wide = {value2_reg[15:0], 16'd0};
        end
        else if (hzero2_reg)
        begin
            c2_wide = c2_sign;
        end
        else if (hsub2_reg)
        begin
            c2_wide = {value2_reg[15], c2_hexp, c2_hfrac};
        end
        else
        begin
            c2_wide = c2_sign | c2_hnorm;
        end
    end

    // single to half, subnormal range: quotient, guard and sticky
    assign c2_subshift = {1'b1, value2_reg[22:0], 24'd0} >> sh2_reg;

    // single to half, normal range
    assign c2_magc = clamp2_reg ? fhbc_pkg::S2H_CLAMP_VALUE : value2_reg[30:0];
    assign c2_nsum = c2_magc + 31'h0000_0fff + {30'd0, c2_magc[13]};
    assign c2_n15  = c2_nsum[27:13] + fhbc_pkg::S2H_REBIAS;

    // single to bfloat16
    assign c2_bsum = {1'b0, value2_reg} + 33'h0_0000_7fff + {32'd0, value2_reg[16]};

    // ---------------- stage 3 ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode3_reg   <= mode2_reg;
            sign3_reg   <= value2_reg[31];
            cat3_reg    <= cat2_reg;
            wide3_reg   <= c2_wide;
            q3_reg      <= c2_subshift[34:24];
            guard3_reg  <= c2_subshift[23];
            sticky3_reg <= |c2_subshift[22:0];
            n15_3_reg   <= c2_n15;
            pay3_reg    <= value2_reg[21:13];
            bnan3_reg   <= bnan2_reg;
            bf3_reg     <= c2_bsum[31:16];
        end
    end

    assign c3_qr = q3_reg + {10'd0, guard3_reg & (sticky3_reg | q3_reg[0])};

    always_comb
    begin
        unique case (mode3_reg)
            fhbc_pkg::MODE_HALF_TO_SINGLE,
            fhbc_pkg::MODE_BF16_TO_SINGLE:
            begin
                c3_result = wide3_reg;
            end
            fhbc_pkg::MODE_SINGLE_TO_HALF:
            begin
                unique case (cat3_reg)
                    fhbc_pkg::CAT_ZERO: c3_result = {16'd0, sign3_reg, 15'd0};
                    fhbc_pkg::CAT_SUB:  c3_result = {16'd0, sign3_reg, 4'd0, c3_qr};
                    fhbc_pkg::CAT_NORM: c3_result = {16'd0, sign3_reg, n15_3_reg};
                    default:            c3_result = {16'd0, sign3_reg, 6'h3f, pay3_reg};
                endcase
            end
            default:
            begin
                c3_result = bnan3_reg ? fhbc_pkg::BF16_NAN : {16'd0, bf3_reg};
            end
        endcase
    end

    // ---------------- output ----------------
    fhbc_skid #(
        .WIDTH (32)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (en),
        .in_data   (c3_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    assign s_tready = en;

endmodule
`default_nettype wire

// File: rtl/fhbc_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhbc_skid
// Output register with a skid entry; the upstream ready is registered.
// ----------------------------------------------------------------------------
module fhbc_skid #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg;
    logic [WIDTH-1:0] skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
`default_nettype wire

// File: dv/float_half_bfloat_convert_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_half_bfloat_convert_unit_test
// Streams conversion requests through the converter in all four directions.
// Each request is checked against an independent model of the conversion.
// Both stream sides idle at random, the output side is held off long enough
// to back up the pipeline, and one pause lets the pipeline drain completely.
// ----------------------------------------------------------------------------

typedef struct {
    fhbc_pkg::mode_t mode;
    logic [31:0]     operand;
    logic [31:0]     result;
} conversion_t;

class convert_scoreboard;
    conversion_t pending_results[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned mode_requests[4];

    function new();
        mismatches      = 0;
        results_checked = 0;
        foreach (mode_requests[i])
            mode_requests[i] = 0;
    endfunction

    function logic [31:0] widen_half(logic [15:0] h);
        logic [31:0] sign;
        logic [31:0] mag;
        logic [31:0] bits;
        int unsigned lead;
        int unsigned i;
        sign = {h[15], 31'b0};
        mag  = {17'b0, h[14:0]};
        if (mag == 0)
            return sign;
        if (mag <= 32'h3ff)
        begin
            lead = 0;
            for (i = 0; i < 10; i++)
                if (mag[i])
                    lead = i;
            bits = mag << (23 - lead);
            return sign | ((lead + 103) << 23) | {9'b0, bits[22:0]};
        end
        bits = (mag << 13) + 32'h3800_0000;
        if (mag >= 32'h7c00)
            bits = bits | 32'h7f80_0000;
        return sign | bits;
    endfunction

    function logic [31:0] narrow_to_half(logic [31:0] x);
        logic [31:0] mag;
        logic [31:0] sign;
        logic [31:0] m;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] halfway;
        int unsigned sh;
        mag  = {1'b0, x[30:0]};
        sign = {16'b0, x[31], 15'b0};
        if (mag < 32'h3300_0001)
            return sign;
        if (mag < 32'h3880_0000)
        begin
            // half subnormal: round in units of 2^-24
            m       = {8'b0, 1'b1, mag[22:0]};
            sh      = 126 - mag[30:23];
            q       = m >> sh;
            rem     = m & ((32'd1 << sh) - 1);
            halfway = 32'd1 << (sh - 1);
            if (rem > halfway || (rem == halfway && q[0]))
                q = q + 1;
            return sign | q;
        end
        if (mag < 32'h7f80_0001)
        begin
            if (mag >= 32'h4780_0001)
                mag = 32'h4780_0000;
            q = (mag + 32'hfff + mag[13]) >> 13;
            q = q + 32'hfffe_4000;
            return sign | {17'b0, q[14:0]};
        end
        return sign | {23'b0, x[21:13]} | 32'h7e00;
    endfunction

    function logic [31:0] narrow_to_bfloat(logic [31:0] x);
        logic [31:0] sum;
        if ((x & 32'h7f80_ffff) > 32'h7f80_0000)
            return 32'h7fa0;
        sum = x + x[16] + 32'h7fff;
        return {16'b0, sum[31:16]};
    endfunction

    function logic [31:0] predict_conversion(fhbc_pkg::mode_t mode, logic [31:0] v);
        case (mode)
            fhbc_pkg::MODE_HALF_TO_SINGLE: return widen_half(v[15:0]);
            fhbc_pkg::MODE_SINGLE_TO_HALF: return narrow_to_half(v);
            fhbc_pkg::MODE_BF16_TO_SINGLE: return {v[15:0], 16'b0};
            default:                       return narrow_to_bfloat(v);
        endcase
    endfunction

    function void note_request(fhbc_pkg::mode_t mode, logic [31:0] operand);
        conversion_t c;
        c.mode    = mode;
        c.operand = operand;
        c.result  = predict_conversion(mode, operand);
        pending_results.push_back(c);
        mode_requests[int'(mode)]++;
    endfunction

    function void check_result(logic [31:0] actual);
        conversion_t c;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h with no request pending", actual);
            return;
        end
        c = pending_results.pop_front();
        results_checked++;
        if (actual !== c.result)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: mode %s operand %h expected %h actual %h",
                         c.mode.name(), c.operand, c.result, actual);
        end
    endfunction
endclass

module float_half_bfloat_convert_unit_test;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [31:0]     s_tdata = 32'b0;   // [31:0] value
    fhbc_pkg::mode_t s_tuser = fhbc_pkg::MODE_HALF_TO_SINGLE;   // [1:0] mode
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [31:0]     m_tdata;           // [31:0] result

    bit          idle_enabled = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    convert_scoreboard sb = new();

    float_half_bfloat_convert_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold-off on demand
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 120;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (idle_enabled)
                m_tready <= ($urandom_range(0, 99) >= 21);
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_request(fhbc_pkg::mode_t mode, logic [31:0] value);
        if (idle_enabled && $urandom_range(0, 99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [31:0] random_operand(fhbc_pkg::mode_t mode);
        logic [31:0] r;
        logic [22:0] mant;
        logic [7:0]  exp8;
        logic [4:0]  exp5;
        bit          sign;
        int unsigned k;
        r    = $urandom;
        sign = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        k = $urandom_range(1, 23);
        if ($urandom_range(0, 1))
            k = (mode == fhbc_pkg::MODE_SINGLE_TO_BF16) ? 16 : 13;
        case ($urandom_range(0, 4))
            0:       mant = '0;
            1:       mant = '1;
            2:       mant = 23'(($urandom << k) | (32'd1 << (k - 1)));   // exact tie
            default: mant = 23'($urandom);
        endcase
        if (mode == fhbc_pkg::MODE_HALF_TO_SINGLE || mode == fhbc_pkg::MODE_BF16_TO_SINGLE)
        begin
            case ($urandom_range(0, 3))
                0:       exp5 = '0;
                1:       exp5 = '1;
                default: exp5 = 5'($urandom);
            endcase
            return {r[31:16], sign, exp5, mant[22:13]};
        end
        case ($urandom_range(0, 5))
            0:       exp8 = '0;
            1:       exp8 = '1;
            2:       exp8 = 8'($urandom_range(101, 143));
            3:       exp8 = 8'($urandom_range(111, 113));
            default: exp8 = 8'($urandom);
        endcase
        return {sign, exp8, mant};
    endfunction

    task automatic send_random(int unsigned count);
        fhbc_pkg::mode_t mode;
        repeat (count)
        begin
            mode = fhbc_pkg::mode_t'($urandom_range(0, 3));
            send_request(mode, random_operand(mode));
        end
    endtask

    task automatic wait_for_drain();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // half to single: zeros, subnormals, normals, inf, NaNs, junk upper half
        send_request(fhbc_pkg::MODE_HALF_TO_SINGLE, 32'h0000_0000);
        send_request(fhbc_pkg::MODE_HALF_TO_SINGLE, 32'hffff_8000);
        send_request(fhbc_pkg::MODE_HALF_TO_SINGLE, 32'h1234_0001);
        send_request(fhbc_pkg::MODE_HALF_TO_SINGLE, 32'h0000_83ff);
        send_request(fhbc_pkg::MODE_HALF_TO_SINGLE, 32'habcd_7bff);
        send_request(fhbc_pkg::MODE_HALF_TO_SINGLE, 32'h0000_fc00);
        send_request(fhbc_pkg::MODE_HALF_TO_SINGLE, 32'h5555_7c01);
        // single to half: underflow, rounding ties, overflow, NaNs
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h3300_0000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'hb300_0001);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h8000_0001);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h33c0_0000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h387f_ffff);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h3f80_1000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h477f_efff);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'hc77f_f000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h7f80_0000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'hff80_0001);
        send_request(fhbc_pkg::MODE_SINGLE_TO_HALF, 32'h7fff_ffff);
        // bfloat16
        send_request(fhbc_pkg::MODE_BF16_TO_SINGLE, 32'hffff_ffff);
        send_request(fhbc_pkg::MODE_BF16_TO_SINGLE, 32'h1234_8000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_BF16, 32'h7f80_0001);
        send_request(fhbc_pkg::MODE_SINGLE_TO_BF16, 32'hffc1_0000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_BF16, 32'h3f80_8000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_BF16, 32'h3f81_8000);
        send_request(fhbc_pkg::MODE_SINGLE_TO_BF16, 32'h7f7f_ffff);
        send_request(fhbc_pkg::MODE_SINGLE_TO_BF16, 32'h0000_0000);

        send_random(260);

        // back up the pipeline against a stalled output
        idle_enabled = 1'b0;
        hold_request = 1'b1;
        send_random(40);
        s_tvalid <= 1'b0;
        wait_for_drain();

        send_random(200);
        idle_enabled = 1'b1;
        send_random(200);
        s_tvalid <= 1'b0;

        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("converted %0d requests: %0d half->single, %0d single->half,",
                 sb.results_checked, sb.mode_requests[0], sb.mode_requests[1]);
        $display("  %0d bfloat->single, %0d single->bfloat; %0d mismatches",
                 sb.mode_requests[2], sb.mode_requests[3], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
